// ===== rtl/core/rv32_pkg.sv =====
`timescale 1ns / 1ps
package rv32_pkg;

  typedef enum logic [1:0] {
    ACT_EXEC = 2'd0,
    ACT_LOAD = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MULD = 7'h01;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SRL  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // Operation class chosen by the front end.
  typedef enum logic [2:0] {
    OPC_ALU  = 3'd0,
    OPC_MUL  = 3'd1,
    OPC_DIV  = 3'd2,
    OPC_LOAD = 3'd3,
    OPC_READ = 3'd4,
    OPC_ILL  = 3'd5,
    OPC_NOP  = 3'd6
  } opclass_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  funct3;
    logic [6:0]  funct7;
    logic [4:0]  src1_index;
    logic [4:0]  src2_index;
    logic [4:0]  dest_index;
    logic [31:0] load_value;
  } in_req_t;

  typedef struct packed {
    logic [31:0] value;
    logic [4:0]  written_index;
    logic        wrote;
    logic        illegal;
    logic [31:0] next_pc;
  } out_res_t;

  // Classified request handed from front to back.
  typedef struct packed {
    opclass_t    opc;
    logic [2:0]  funct3;
    logic        alt;
    logic [4:0]  src1_index;
    logic [4:0]  src2_index;
    logic [4:0]  dest_index;
    logic [31:0] load_value;
  } cmd_t;

endpackage

// ===== rtl/core/rv32_front.sv =====
`timescale 1ns / 1ps
module rv32_front (
  input  logic             rst_n,
  input  logic             in_valid,
  input  rv32_pkg::in_req_t in_req,
  input  logic             q_full,
  output logic             q_push,
  output rv32_pkg::cmd_t   q_cmd
);

  // Decode the request into an operation class.
  always_comb begin
    q_cmd            = '0;
    q_cmd.funct3     = in_req.funct3;
    q_cmd.alt        = (in_req.funct7 == rv32_pkg::F7_ALT);
    q_cmd.src1_index = in_req.src1_index;
    q_cmd.src2_index = in_req.src2_index;
    q_cmd.dest_index = in_req.dest_index;
    q_cmd.load_value = in_req.load_value;
    case (in_req.action)
      rv32_pkg::ACT_EXEC: begin
        if (in_req.funct7 == rv32_pkg::F7_BASE) begin
          q_cmd.opc = rv32_pkg::OPC_ALU;
        end else if (in_req.funct7 == rv32_pkg::F7_ALT) begin
          q_cmd.opc = (in_req.funct3 == rv32_pkg::F3_ADD || in_req.funct3 == rv32_pkg::F3_SRL)
                      ? rv32_pkg::OPC_ALU : rv32_pkg::OPC_ILL;
        end else if (in_req.funct7 == rv32_pkg::F7_MULD) begin
          q_cmd.opc = in_req.funct3[2] ? rv32_pkg::OPC_DIV : rv32_pkg::OPC_MUL;
        end else begin
          q_cmd.opc = rv32_pkg::OPC_ILL;
        end
      end
      rv32_pkg::ACT_LOAD: q_cmd.opc = rv32_pkg::OPC_LOAD;
      rv32_pkg::ACT_READ: q_cmd.opc = rv32_pkg::OPC_READ;
      default:            q_cmd.opc = rv32_pkg::OPC_NOP;
    endcase
  end

  assign q_push = in_valid && !q_full && rst_n;

endmodule

// ===== rtl/core/rv32_queue.sv =====
`timescale 1ns / 1ps
module rv32_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rv32_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output rv32_pkg::cmd_t head
);

  // Two-entry queue between decode and execution.
  rv32_pkg::cmd_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/core/rv32_div.sv =====
`timescale 1ns / 1ps
module rv32_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);

  // Unsigned restoring divider, one quotient bit per cycle.
  logic [31:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] d_r;
  logic [5:0]  cnt_r;
  logic        run_r;
  logic [32:0] trial;
  logic [32:0] shifted;

  always_comb begin
    shifted = {rem_r[31:0], q_r[31]};
    trial   = shifted - {1'b0, d_r};
    q_nxt   = {q_r[30:0], ~trial[32]};
    rem_nxt = trial[32] ? shifted : trial;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (run_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= 6'd0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'd31) run_r <= 1'b0;
    end
  end

  assign done      = run_r && (cnt_r == 6'd31);
  assign quotient  = q_nxt;
  assign remainder = rem_nxt[31:0];

endmodule

// ===== rtl/core/rv32_back.sv =====
`timescale 1ns / 1ps
module rv32_back #(
  parameter int REGISTER_COUNT = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  input  logic               q_not_empty,
  input  rv32_pkg::cmd_t     q_head,
  output logic               q_pop,
  output logic               idle,
  output logic               out_strobe,
  output rv32_pkg::out_res_t out_res
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MUL   = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_WAIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [31:0] rf_r [32];
  logic [31:0] pc_r;
  logic [31:0] a, b;
  rv32_pkg::cmd_t cmd_r;
  logic [31:0] a_r, b_r;
  logic [63:0] prod_r;
  logic        neg_a_r, neg_b_r;

  // Register file read, with x0 and missing registers as zero.
  function automatic logic [31:0] rd(input logic [31:0] f [32], input logic [4:0] i);
    logic ok;
    ok = (i != 5'd0) && ({1'b0, i} < 6'(REGISTER_COUNT));
    return ok ? f[i] : 32'd0;
  endfunction

  assign a = rd(rf_r, q_head.src1_index);
  assign b = rd(rf_r, q_head.src2_index);

  // Combinational ALU.
  logic [31:0] alu_res;
  logic [4:0]  sh;
  always_comb begin
    sh = b[4:0];
    case (q_head.funct3)
      rv32_pkg::F3_ADD:  alu_res = q_head.alt ? a - b : a + b;
      rv32_pkg::F3_SLL:  alu_res = a << sh;
      rv32_pkg::F3_SLT:  alu_res = {31'd0, $signed(a) < $signed(b)};
      rv32_pkg::F3_SLTU: alu_res = {31'd0, a < b};
      rv32_pkg::F3_XOR:  alu_res = a ^ b;
      rv32_pkg::F3_SRL:  alu_res = q_head.alt ? 32'($signed(a) >>> sh) : a >> sh;
      rv32_pkg::F3_OR:   alu_res = a | b;
      default:           alu_res = a & b;
    endcase
  end

  // Divider operands are magnitudes for the signed forms.
  logic        sgn;
  logic        div_start, div_done;
  logic [31:0] dq, dr;
  assign sgn = ~q_head.funct3[0];
  assign div_start = (state_r == ST_IDLE) && q_not_empty && q_head.opc == rv32_pkg::OPC_DIV;

  rv32_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  ((sgn && a[31]) ? 32'(0 - a) : a),
    .divisor   ((sgn && b[31]) ? 32'(0 - b) : b),
    .done      (div_done),
    .quotient  (dq),
    .remainder (dr)
  );

  // Finishing values for multi-cycle operations.
  logic [31:0] mul_res, div_res;
  always_comb begin
    case (cmd_r.funct3[1:0])
      2'd0:    mul_res = prod_r[31:0];
      default: mul_res = prod_r[63:32];
    endcase
    if (b_r == 32'd0) begin
      div_res = cmd_r.funct3[1] ? a_r : 32'hFFFF_FFFF;
    end else if (!cmd_r.funct3[1]) begin
      div_res = (!cmd_r.funct3[0] && (neg_a_r != neg_b_r)) ? 32'(0 - dq) : dq;
    end else begin
      div_res = (!cmd_r.funct3[0] && neg_a_r) ? 32'(0 - dr) : dr;
    end
  end

  // Product from the registered operands a_r and b_r.
  logic signed [32:0] ma, mb;
  logic signed [63:0] prod_w;
  always_comb begin
    ma = {(cmd_r.funct3 == 3'd1 || cmd_r.funct3 == 3'd2) && a_r[31], a_r};
    mb = {(cmd_r.funct3 == 3'd1) && b_r[31], b_r};
    prod_w = ma * mb;
  end

  // Sequencer and write-back.
  logic        fin;
  logic [31:0] fin_val;
  logic        fin_pc;
  logic [4:0]  fin_dst;
  logic        fin_wr_ok;
  logic        fin_ill;
  logic        fin_wen;

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    fin       = 1'b0;
    fin_val   = '0;
    fin_pc    = 1'b0;
    fin_ill   = 1'b0;
    fin_wen   = 1'b0;
    fin_dst   = q_head.dest_index;
    case (state_r)
      ST_IDLE: begin
        if (q_not_empty) begin
          q_pop = 1'b1;
          case (q_head.opc)
            rv32_pkg::OPC_ALU: begin
              fin = 1'b1; fin_val = alu_res; fin_pc = 1'b1; fin_wen = 1'b1;
            end
            rv32_pkg::OPC_MUL:  state_nxt = ST_MUL;
            rv32_pkg::OPC_DIV:  state_nxt = ST_DIV;
            rv32_pkg::OPC_LOAD: begin
              fin = 1'b1; fin_val = q_head.load_value; fin_wen = 1'b1;
            end
            rv32_pkg::OPC_READ: begin fin = 1'b1; fin_val = a; end
            rv32_pkg::OPC_ILL:  begin fin = 1'b1; fin_ill = 1'b1; end
            default:            fin = 1'b1;
          endcase
        end
      end
      ST_MUL: state_nxt = ST_WAIT;
      ST_WAIT: begin
        fin = 1'b1; fin_val = mul_res; fin_pc = 1'b1; fin_wen = 1'b1;
        fin_dst = cmd_r.dest_index; state_nxt = ST_IDLE;
      end
      ST_DIV: begin
        if (div_done) begin
          fin = 1'b1; fin_val = div_res; fin_pc = 1'b1; fin_wen = 1'b1;
          fin_dst = cmd_r.dest_index; state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    fin_wr_ok = fin_wen && (fin_dst != 5'd0) && ({1'b0, fin_dst} < 6'(REGISTER_COUNT));
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r   <= q_head;
      a_r     <= a;
      b_r     <= b;
      neg_a_r <= a[31];
      neg_b_r <= b[31];
    end
    if (state_r == ST_MUL) begin
      prod_r <= prod_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      pc_r       <= '0;
      out_strobe <= 1'b0;
      for (int i = 0; i < 32; i++) rf_r[i] <= '0;
    end else begin
      state_r    <= state_nxt;
      out_strobe <= fin;
      if (fin_wr_ok) rf_r[fin_dst] <= fin_val;
      if (cfg_we) begin
        pc_r <= {cfg_wdata[31:2], 2'b00};
      end else if (fin && fin_pc) begin
        pc_r <= pc_r + 32'd4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_res.value         <= fin_val;
      out_res.written_index <= fin_wr_ok ? fin_dst : 5'd0;
      out_res.wrote         <= fin_wr_ok;
      out_res.illegal       <= fin_ill;
      out_res.next_pc       <= fin_pc ? pc_r + 32'd4 : pc_r;
    end
  end

  assign idle = (state_r == ST_IDLE);

endmodule

// ===== rtl/core/rv32im_register_alu_execute.sv =====
`timescale 1ns / 1ps
// RV32IM register-register execute block with its own register file and pc.
// Input channel: drive in_req and pulse start while busy is low; the request
// is taken at that clock edge. Configuration: cfg_we with cfg_wdata loads
// start_address (low two bits dropped) into the program counter at once;
// write it only while the block is idle.
// Result channel: out_strobe is high for exactly one cycle with out_res;
// the receiver cannot stall it.
// Path: ALU, load, read and illegal requests pass the queue and then the
// write-back register; multiplies also pass operand capture and the product
// register; divides and remainders run in the one-bit-per-cycle restoring
// divider before the write-back register.
// A decode front end feeds a two-entry queue; the execute back end handles
// one request at a time, so busy rises while the queue is full.
// Reset clears the register file, the pc, the queue and the sequencer.
module rv32im_register_alu_execute #(
  parameter int REGISTER_COUNT = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rv32_pkg::in_req_t  in_req,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  output logic               out_strobe,
  output rv32_pkg::out_res_t out_res
);

  logic           q_full, q_push, q_ne, q_pop, idle;
  rv32_pkg::cmd_t q_cmd, q_head;

  assign busy = q_full;

  rv32_front u_front (
    .rst_n(rst_n), .in_valid(start), .in_req(in_req),
    .q_full(q_full), .q_push(q_push), .q_cmd(q_cmd)
  );

  rv32_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_cmd(q_cmd), .pop(q_pop),
    .full(q_full), .not_empty(q_ne), .head(q_head)
  );

  rv32_back #(.REGISTER_COUNT(REGISTER_COUNT)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .q_not_empty(q_ne), .q_head(q_head), .q_pop(q_pop), .idle(idle),
    .out_strobe(out_strobe), .out_res(out_res)
  );

  // A strobe never reports a write together with illegal.
  a_wr_ill: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_res.wrote && out_res.illegal)) else $error("write on illegal");

  // The queue is only popped while the back end sits idle.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (idle && q_ne)) else $error("pop while busy");

  // Register zero is never reported as written.
  a_x0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_res.wrote) |-> (out_res.written_index != 5'd0))
    else $error("x0 written");

endmodule
